// File: rtl/pfy_pkg.sv
// Shared types and constants for the partial Fisher-Yates sampler.
`default_nettype none

package pfy_pkg;

   localparam int POPULATION_MAX_DEF = 1024;
   localparam int WORD_W             = 31;
   localparam int INDEX_OUT_W        = 10;
   localparam int POP_REG_W          = 11;
   localparam int DRAWS_REG_W        = 11;
   localparam int REPS_W             = 16;
   localparam int CSR_DATA_W         = 16;
   localparam int CSR_INDEX_W        = 2;
   localparam int REQ_DATA_W         = 32;
   localparam int RSP_DATA_W         = 16;
   localparam int EPOCH_W            = 8;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POPULATION = 2'd0,
      CSR_DRAWS      = 2'd1,
      CSR_REPS       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_RD_A,
      ST_RD_B,
      ST_WR_A,
      ST_WR_B
   } eng_state_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } queue_item_type;

   typedef struct packed {
      logic [INDEX_OUT_W-1:0] index;
      logic                   sample_end;
      logic                   all_done;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/partial_fisher_yates_sampler_top.sv
// Top level of the partial Fisher-Yates sampler: register file, queue and draw engine.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tdata[30:0] random_word
//   rsp      out        rsp_tvalid/rsp_tready   tdata[9:0] chosen_index, tlast sample_end,
//                                               tuser all_done
//   csr      in         csr_write_enable        csr_index, csr_wdata
//
// A draw passes an issue step, the bit-serial remainder unit (31 steps and a result step),
// then the permutation table (two reads, two writes).
// A draw that must first restore the table after a register change does so in the idle state.
// After reset, and after every 255 sample restores when the epoch mark wraps, a clearing
// pass runs through all POPULATION_MAX table entries; only the queue takes beats then.
// Reset is synchronous, active high. A two-beat input queue and the output register
// let either side stall without stopping the other.
`default_nettype none

module partial_fisher_yates_sampler_top #(
   parameter int POPULATION_MAX = pfy_pkg::POPULATION_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [pfy_pkg::REQ_DATA_W-1:0]   req_tdata,   // [30:0] random_word
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [pfy_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [9:0] chosen_index
   output logic                                  rsp_tlast,   // sample_end
   output logic                                  rsp_tuser,   // all_done
   input  wire logic                             csr_write_enable,
   input  wire logic [pfy_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pfy_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SLOT_W = $clog2(POPULATION_MAX + 1);

   logic [pfy_pkg::POP_REG_W-1:0]   pop_reg_ff, pop_reg_in;
   logic [pfy_pkg::DRAWS_REG_W-1:0] draws_reg_ff, draws_reg_in;
   logic [pfy_pkg::REPS_W-1:0]      reps_reg_ff, reps_reg_in;

   logic [31:0]                     pop_wide;
   logic [31:0]                     draws_wide;
   logic [SLOT_W-1:0]               pop_eff;
   logic [SLOT_W-1:0]               draws_eff;
   logic [pfy_pkg::REPS_W-1:0]      reps_eff;

   pfy_pkg::queue_item_type         head;
   logic                            head_pop;
   pfy_pkg::result_type             result;

   always_comb begin
      pop_reg_in   = pop_reg_ff;
      draws_reg_in = draws_reg_ff;
      reps_reg_in  = reps_reg_ff;
      if (csr_write_enable) begin
         unique case (pfy_pkg::csr_index_type'(csr_index))
            pfy_pkg::CSR_POPULATION: pop_reg_in   = csr_wdata[pfy_pkg::POP_REG_W-1:0];
            pfy_pkg::CSR_DRAWS:      draws_reg_in = csr_wdata[pfy_pkg::DRAWS_REG_W-1:0];
            pfy_pkg::CSR_REPS:       reps_reg_in  = csr_wdata[pfy_pkg::REPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_reg_ff   <= pfy_pkg::POP_REG_W'(1024);
         draws_reg_ff <= pfy_pkg::DRAWS_REG_W'(1);
         reps_reg_ff  <= pfy_pkg::REPS_W'(1);
      end else begin
         pop_reg_ff   <= pop_reg_in;
         draws_reg_ff <= draws_reg_in;
         reps_reg_ff  <= reps_reg_in;
      end
   end

   // clamp population to 1..POPULATION_MAX and draws to 1..population
   always_comb begin
      pop_wide = 32'(pop_reg_ff);
      if (pop_wide == 32'd0) begin
         pop_wide = 32'd1;
      end else if (pop_wide > 32'(POPULATION_MAX)) begin
         pop_wide = 32'(POPULATION_MAX);
      end
      draws_wide = 32'(draws_reg_ff);
      if (draws_wide == 32'd0) begin
         draws_wide = 32'd1;
      end else if (draws_wide > pop_wide) begin
         draws_wide = pop_wide;
      end
      pop_eff   = SLOT_W'(pop_wide);
      draws_eff = SLOT_W'(draws_wide);
      reps_eff  = (reps_reg_ff == '0) ? pfy_pkg::REPS_W'(1) : reps_reg_ff;
   end

   pfy_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .head      (head),
      .pop       (head_pop)
   );

   pfy_engine #(
      .POPULATION_MAX(POPULATION_MAX)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .pop_eff  (pop_eff),
      .draws_eff(draws_eff),
      .reps_eff (reps_eff),
      .head     (head),
      .pop      (head_pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .result   (result)
   );

   assign rsp_tdata = {{(pfy_pkg::RSP_DATA_W - pfy_pkg::INDEX_OUT_W){1'b0}}, result.index};
   assign rsp_tlast = result.sample_end;
   assign rsp_tuser = result.all_done;

endmodule

`default_nettype wire

// File: rtl/pfy_front.sv
// Input queue: accepts random-word beats and holds them for the draw engine.
`default_nettype none

module pfy_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [pfy_pkg::REQ_DATA_W-1:0] req_tdata,  // [30:0] random_word
   output pfy_pkg::queue_item_type          head,
   input  wire logic                        pop
);

   localparam int DEPTH = pfy_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [pfy_pkg::WORD_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       push;
   logic                       take;

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign take       = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_tdata[pfy_pkg::WORD_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/pfy_modulo.sv
// Restoring bit-serial remainder of a random word by the count of entries left.
`default_nettype none

module pfy_modulo #(
   parameter int DIV_W = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pfy_pkg::WORD_W-1:0]  dividend,
   input  wire logic [DIV_W-1:0]            divisor,
   output logic                             done,
   output logic [DIV_W-1:0]                 remainder
);

   localparam int CNT_W = $clog2(pfy_pkg::WORD_W + 1);

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [pfy_pkg::WORD_W-1:0] word_ff, word_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]           div_ff, div_in;
   logic                       done_ff, done_in;
   logic [DIV_W:0]             trial;
   logic                       fits;

   assign trial     = {rem_ff, word_ff[pfy_pkg::WORD_W-1]};
   assign fits      = (trial >= {1'b0, div_ff});
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      word_in = word_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = CNT_W'(pfy_pkg::WORD_W);
         word_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         word_in = {word_ff[pfy_pkg::WORD_W-2:0], 1'b0};
         rem_in  = fits ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

endmodule

`default_nettype wire

// File: rtl/pfy_engine.sv
// Draw engine: permutation table, swap sequencer, sample and repetition counters.
`default_nettype none

module pfy_engine #(
   parameter int POPULATION_MAX = pfy_pkg::POPULATION_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(POPULATION_MAX+1)-1:0] pop_eff,
   input  wire logic [$clog2(POPULATION_MAX+1)-1:0] draws_eff,
   input  wire logic [pfy_pkg::REPS_W-1:0]        reps_eff,
   input  wire pfy_pkg::queue_item_type           head,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pfy_pkg::result_type                    result
);

   localparam int IDX_W   = $clog2(POPULATION_MAX);
   localparam int SLOT_W  = $clog2(POPULATION_MAX + 1);
   localparam int EPOCH_W = pfy_pkg::EPOCH_W;
   localparam int ENTRY_W = EPOCH_W + IDX_W;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   pfy_pkg::eng_state_type state_ff, state_in;

   logic [ENTRY_W-1:0]         table_mem [POPULATION_MAX];
   logic [ENTRY_W-1:0]         rd_data_ff;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   logic [ENTRY_W-1:0]         mem_wdata;
   logic [IDX_W-1:0]           mem_raddr;

   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic [IDX_W-1:0]           pick_ff, pick_in;
   logic [IDX_W-1:0]           a_ff, a_in;
   logic [IDX_W-1:0]           b_ff, b_in;
   logic [IDX_W-1:0]           clr_ff, clr_in;
   logic [EPOCH_W-1:0]         epoch_ff, epoch_in;
   logic [pfy_pkg::REPS_W-1:0] reps_ff, reps_in;
   logic                       out_valid_ff, out_valid_in;
   pfy_pkg::result_type        result_ff, result_in;

   logic                       div_start;
   logic                       div_done;
   logic [SLOT_W-1:0]          div_rem;
   logic [SLOT_W-1:0]          left;
   logic [IDX_W-1:0]           rd_value;
   logic                       rd_hit;
   logic                       slot_ge_d;
   logic                       clr_last;
   logic                       out_free;
   logic                       out_load;
   logic [SLOT_W-1:0]          slot_inc;
   logic                       ends;
   logic [pfy_pkg::REPS_W-1:0] reps_inc;
   logic                       last_rep;

   assign left      = pop_eff - SLOT_W'(slot_ff);
   assign slot_ge_d = (SLOT_W'(slot_ff) >= draws_eff);
   assign clr_last  = (clr_ff == IDX_W'(POPULATION_MAX - 1));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rd_hit    = (rd_data_ff[ENTRY_W-1:IDX_W] == epoch_ff);
   assign rd_value  = rd_data_ff[IDX_W-1:0];
   assign slot_inc  = SLOT_W'(slot_ff) + 1'b1;
   assign ends      = (slot_inc >= draws_eff);
   assign reps_inc  = reps_ff + 1'b1;
   assign last_rep  = (reps_inc >= reps_eff);

   pfy_modulo #(
      .DIV_W(SLOT_W)
   ) u_modulo (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head.word),
      .divisor  (left),
      .done     (div_done),
      .remainder(div_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfy_pkg::ST_CLEAR: begin
            if (clr_last) state_in = pfy_pkg::ST_IDLE;
         end
         pfy_pkg::ST_IDLE: begin
            if (head.valid) begin
               if (!slot_ge_d) begin
                  state_in = pfy_pkg::ST_DIV;
               end else if (epoch_ff == EPOCH_MAX) begin
                  state_in = pfy_pkg::ST_CLEAR;
               end
            end
         end
         pfy_pkg::ST_DIV: begin
            if (div_done) state_in = pfy_pkg::ST_RD_A;
         end
         pfy_pkg::ST_RD_A: state_in = pfy_pkg::ST_RD_B;
         pfy_pkg::ST_RD_B: state_in = pfy_pkg::ST_WR_A;
         pfy_pkg::ST_WR_A: state_in = pfy_pkg::ST_WR_B;
         pfy_pkg::ST_WR_B: begin
            if (out_free) begin
               state_in = (ends && epoch_ff == EPOCH_MAX) ? pfy_pkg::ST_CLEAR
                                                          : pfy_pkg::ST_IDLE;
            end
         end
         default: state_in = pfy_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = {epoch_ff, b_ff};
      mem_raddr = slot_ff;
      div_start = 1'b0;
      pop       = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         pfy_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         pfy_pkg::ST_IDLE: begin
            div_start = head.valid && !slot_ge_d;
            pop       = head.valid && !slot_ge_d;
         end
         pfy_pkg::ST_DIV: begin
         end
         pfy_pkg::ST_RD_A: begin
            mem_raddr = slot_ff;
         end
         pfy_pkg::ST_RD_B: begin
            mem_raddr = pick_ff;
         end
         pfy_pkg::ST_WR_A: begin
            mem_we    = 1'b1;
            mem_waddr = pick_ff;
            mem_wdata = {epoch_ff, a_ff};
         end
         pfy_pkg::ST_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = {epoch_ff, b_ff};
            out_load  = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      slot_in      = slot_ff;
      pick_in      = pick_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      clr_in       = clr_ff;
      epoch_in     = epoch_ff;
      reps_in      = reps_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      result_in    = result_ff;
      case (state_ff)
         pfy_pkg::ST_CLEAR: begin
            clr_in = clr_last ? '0 : clr_ff + 1'b1;
            if (clr_last) epoch_in = EPOCH_W'(1);
         end
         pfy_pkg::ST_IDLE: begin
            if (head.valid && slot_ge_d) begin
               slot_in = '0;
               if (epoch_ff != EPOCH_MAX) epoch_in = epoch_ff + 1'b1;
            end else if (head.valid) begin
               reps_in = (reps_ff >= reps_eff) ? '0 : reps_ff;
            end
         end
         pfy_pkg::ST_DIV: begin
            if (div_done) pick_in = IDX_W'(SLOT_W'(slot_ff) + div_rem);
         end
         pfy_pkg::ST_RD_B: begin
            a_in = rd_hit ? rd_value : slot_ff;
         end
         pfy_pkg::ST_WR_A: begin
            b_in = rd_hit ? rd_value : pick_ff;
         end
         pfy_pkg::ST_WR_B: begin
            if (out_load) begin
               out_valid_in         = 1'b1;
               result_in.index      = pfy_pkg::INDEX_OUT_W'(b_ff);
               result_in.sample_end = ends;
               result_in.all_done   = ends && last_rep;
               if (ends) begin
                  slot_in = '0;
                  reps_in = last_rep ? '0 : reps_inc;
                  if (epoch_ff != EPOCH_MAX) epoch_in = epoch_ff + 1'b1;
               end else begin
                  slot_in = IDX_W'(slot_inc);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfy_pkg::ST_CLEAR;
         slot_ff      <= '0;
         clr_ff       <= '0;
         epoch_ff     <= EPOCH_W'(1);
         reps_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         reps_ff      <= reps_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff   <= pick_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   assign rsp_valid = out_valid_ff;
   assign result    = result_ff;

   a_load_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == pfy_pkg::ST_WR_B))
      else $error("result raised outside the final swap write");

   a_done_ends_sample: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.all_done) |-> result_ff.sample_end)
      else $error("all_done without sample_end");

   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pfy_pkg::ST_DIV))
      else $error("modulo finished outside the divide step");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pfy_pkg::ST_CLEAR) |-> (epoch_ff != '0))
      else $error("epoch mark equals the cleared tag");

endmodule

`default_nettype wire

// File: bench/tb_partial_fisher_yates_sampler_top.sv
// Testbench for the partial Fisher-Yates sampler: directed table, then checked random draws.
`timescale 1ns / 100ps

module tb_partial_fisher_yates_sampler_top;

   localparam logic [pfy_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_DRAWS    = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 10000;
   localparam int TAIL_CYCLES     = 40;

   typedef enum logic {ROW_CSR, ROW_DRAW} row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [pfy_pkg::CSR_INDEX_W-1:0]  csr_sel;
      logic [pfy_pkg::CSR_DATA_W-1:0]   csr_value;
      logic [pfy_pkg::WORD_W-1:0]       word;
      logic                             typed;
      pfy_pkg::result_type              due;
   } script_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [pfy_pkg::REQ_DATA_W-1:0]    req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [pfy_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              rsp_tlast;
   logic                              rsp_tuser;
   logic                              csr_write_enable;
   logic [pfy_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [pfy_pkg::CSR_DATA_W-1:0]    csr_wdata;

   // shadow registers and permutation state of the predictor
   logic [pfy_pkg::POP_REG_W-1:0]     pop_reg;
   logic [pfy_pkg::DRAWS_REG_W-1:0]   draws_reg;
   logic [pfy_pkg::REPS_W-1:0]        reps_reg;
   logic [pfy_pkg::INDEX_OUT_W-1:0]   perm_entries [pfy_pkg::POPULATION_MAX_DEF];
   bit                                entry_set [pfy_pkg::POPULATION_MAX_DEF];
   int unsigned                       slot_pos;
   int unsigned                       reps_done;

   pfy_pkg::result_type               draws_due [$];
   script_row_type                    script [$];
   int                                mismatches = 0;
   int                                quiet_cycles = 0;
   bit                                steady = 1'b0;
   bit                                hold_request = 1'b0;

   partial_fisher_yates_sampler_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic script_row_type csr_row(logic [pfy_pkg::CSR_INDEX_W-1:0] sel,
                                              logic [pfy_pkg::CSR_DATA_W-1:0] value);
      script_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_sel = sel;
      r.csr_value = value;
      return r;
   endfunction

   function automatic script_row_type draw_row(logic [pfy_pkg::WORD_W-1:0] word,
                                               logic typed,
                                               logic [pfy_pkg::INDEX_OUT_W-1:0] index,
                                               logic sample_end, logic all_done);
      script_row_type r;
      r = '0;
      r.kind = ROW_DRAW;
      r.word = word;
      r.typed = typed;
      r.due.index = index;
      r.due.sample_end = sample_end;
      r.due.all_done = all_done;
      return r;
   endfunction

   task automatic add_row(input script_row_type r);
      script.insert(script.size(), r);
   endtask

   function automatic int unsigned slot_value(int unsigned i);
      return entry_set[i] ? int'(perm_entries[i]) : i;
   endfunction

   task automatic restore_table();
      foreach (entry_set[i]) entry_set[i] = 1'b0;
   endtask

   task automatic predict_draw(input logic [pfy_pkg::WORD_W-1:0] word,
                               output pfy_pkg::result_type res);
      int unsigned p, d, r, left, pick, a, b;
      p = pop_reg;
      if (p < 1) p = 1;
      if (p > pfy_pkg::POPULATION_MAX_DEF) p = pfy_pkg::POPULATION_MAX_DEF;
      d = draws_reg;
      if (d < 1) d = 1;
      if (d > p) d = p;
      r = (reps_reg == 0) ? 1 : reps_reg;
      if (slot_pos >= d) begin
         restore_table();
         slot_pos = 0;
      end
      if (reps_done >= r) reps_done = 0;
      left = p - slot_pos;
      pick = slot_pos + word % left;
      a = slot_value(slot_pos);
      b = slot_value(pick);
      perm_entries[pick] = a[pfy_pkg::INDEX_OUT_W-1:0];
      entry_set[pick] = 1'b1;
      perm_entries[slot_pos] = b[pfy_pkg::INDEX_OUT_W-1:0];
      entry_set[slot_pos] = 1'b1;
      slot_pos++;
      res.index = b[pfy_pkg::INDEX_OUT_W-1:0];
      res.sample_end = 1'b0;
      res.all_done = 1'b0;
      if (slot_pos >= d) begin
         res.sample_end = 1'b1;
         restore_table();
         slot_pos = 0;
         reps_done++;
         if (reps_done >= r) begin
            res.all_done = 1'b1;
            reps_done = 0;
         end
      end
   endtask

   task automatic csr_write(input logic [pfy_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [pfy_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (sel)
         pfy_pkg::CSR_POPULATION: pop_reg = value[pfy_pkg::POP_REG_W-1:0];
         pfy_pkg::CSR_DRAWS:      draws_reg = value[pfy_pkg::DRAWS_REG_W-1:0];
         pfy_pkg::CSR_REPS:       reps_reg = value[pfy_pkg::REPS_W-1:0];
         default:                 ;
      endcase
   endtask

   task automatic drain_draws();
      req_tvalid <= 1'b0;
      while (draws_due.size() != 0) @(posedge clock);
   endtask

   task automatic sender_gap();
      while (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [pfy_pkg::WORD_W-1:0] word, input logic typed,
                            input pfy_pkg::result_type typed_res);
      pfy_pkg::result_type res;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, word};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_draw(word, res);
      draws_due.insert(draws_due.size(), typed ? typed_res : res);
   endtask

   initial begin : stimulus
      script_row_type                   row;
      logic [31:0]                      bits;
      logic [pfy_pkg::POP_REG_W-1:0]    pick11;
      logic [pfy_pkg::CSR_DATA_W-1:0]   value16;
      int unsigned                      roll, phase, phase_items, sent;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      pop_reg = 11'd1024;
      draws_reg = 11'd1;
      reps_reg = 16'd1;
      foreach (perm_entries[i]) perm_entries[i] = '0;
      restore_table();
      slot_pos = 0;
      reps_done = 0;

      add_row(draw_row(31'd5, 1'b1, 10'd5, 1'b1, 1'b1));
      add_row(draw_row(31'h7FFFFFFF, 1'b1, 10'd1023, 1'b1, 1'b1));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_POPULATION, 16'd0));
      add_row(draw_row(31'h7FFFFFFF, 1'b1, 10'd0, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_POPULATION, 16'hFFFF));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'd0));
      add_row(draw_row(31'd1023, 1'b1, 10'd1023, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_POPULATION, 16'd2));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'd2047));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'd0));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b0, 1'b0));
      add_row(draw_row(31'd0, 1'b1, 10'd1, 1'b1, 1'b1));
      add_row(draw_row(31'd1, 1'b1, 10'd1, 1'b0, 1'b0));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'd1));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'd3));
      add_row(draw_row(31'd1, 1'b1, 10'd1, 1'b1, 1'b0));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b1, 1'b0));
      add_row(draw_row(31'd3, 1'b1, 10'd1, 1'b1, 1'b1));
      add_row(csr_row(CSR_UNUSED, 16'hFFFF));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b1, 1'b0));
      add_row(csr_row(pfy_pkg::CSR_POPULATION, 16'hF808));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'd4));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'd1));
      add_row(draw_row(31'd2, 1'b1, 10'd2, 1'b0, 1'b0));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'hF801));
      add_row(draw_row(31'd7, 1'b1, 10'd7, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'd5));
      add_row(draw_row(31'd0, 1'b1, 10'd0, 1'b1, 1'b0));
      add_row(draw_row(31'd1, 1'b1, 10'd1, 1'b1, 1'b0));
      add_row(draw_row(31'd2, 1'b1, 10'd2, 1'b1, 1'b0));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'd2));
      add_row(draw_row(31'd3, 1'b1, 10'd3, 1'b1, 1'b0));
      add_row(draw_row(31'd4, 1'b1, 10'd4, 1'b1, 1'b1));
      add_row(csr_row(pfy_pkg::CSR_POPULATION, 16'd1024));
      add_row(csr_row(pfy_pkg::CSR_DRAWS, 16'd1024));
      add_row(csr_row(pfy_pkg::CSR_REPS, 16'hFFFF));
      add_row(draw_row(31'h2AAAAAAA, 1'b0, '0, 1'b0, 1'b0));
      add_row(draw_row(31'h55555555, 1'b0, '0, 1'b0, 1'b0));
      add_row(draw_row(31'h7FFFFFFF, 1'b0, '0, 1'b0, 1'b0));
      add_row(draw_row(31'd0, 1'b0, '0, 1'b0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_CSR) begin
            drain_draws();
            csr_write(row.csr_sel, row.csr_value);
         end else begin
            sender_gap();
            send_word(row.word, row.typed, row.due);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_DRAWS) begin
         drain_draws();
         if ($urandom_range(9) < 7) begin
            roll = $urandom_range(9);
            if (roll < 5) pick11 = 11'($urandom_range(16, 1));
            else if (roll < 7) pick11 = 11'($urandom_range(1024, 17));
            else if (roll == 7) pick11 = 11'd1024;
            else if (roll == 8) pick11 = '0;
            else pick11 = 11'($urandom_range(2047, 1025));
            csr_write(pfy_pkg::CSR_POPULATION, {5'($urandom_range(31)), pick11});
         end
         if ($urandom_range(9) < 7) begin
            roll = $urandom_range(9);
            if (roll < 5) pick11 = 11'($urandom_range(8, 1));
            else if (roll < 7) pick11 = 11'($urandom_range(64, 1));
            else if (roll == 7) pick11 = '0;
            else if (roll == 8) pick11 = 11'd2047;
            else pick11 = 11'($urandom_range(2047));
            csr_write(pfy_pkg::CSR_DRAWS, {5'($urandom_range(31)), pick11});
         end
         if ($urandom_range(9) < 6) begin
            roll = $urandom_range(9);
            if (roll < 6) value16 = 16'($urandom_range(6, 1));
            else if (roll == 6) value16 = '0;
            else if (roll == 7) value16 = 16'hFFFF;
            else value16 = 16'($urandom);
            csr_write(pfy_pkg::CSR_REPS, value16);
         end
         if ($urandom_range(9) == 0) csr_write(CSR_UNUSED, 16'($urandom));
         steady = (phase == 3);
         if (phase == 5) hold_request = 1'b1;
         phase_items = steady ? 300 : $urandom_range(150, 20);
         if (phase_items > RANDOM_DRAWS - sent) phase_items = RANDOM_DRAWS - sent;
         repeat (phase_items) begin
            sender_gap();
            roll = $urandom_range(99);
            bits = $urandom;
            if (roll < 4) bits = '0;
            else if (roll < 8) bits = '1;
            send_word(bits[pfy_pkg::WORD_W-1:0], 1'b0, '0);
            sent++;
         end
         phase++;
      end

      drain_draws();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin : check_results
      pfy_pkg::result_type due;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (draws_due.size() == 0) begin
            $display("%0t: result beat with nothing expected: index %0d last %0b user %0b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            due = draws_due.pop_front();
            if (rsp_tdata !== pfy_pkg::RSP_DATA_W'(due.index)) begin
               $display("%0t: chosen_index expected %0d actual %0d", $time, due.index,
                        rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== due.sample_end) begin
               $display("%0t: sample_end expected %0b actual %0b", $time, due.sample_end,
                        rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== due.all_done) begin
               $display("%0t: all_done expected %0b actual %0b", $time, due.all_done,
                        rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
